// File: rtl/core/assert_macros.svh
// ---------------------------------------------------------------------------
// Assertion macros
// Concurrent assertion helpers shared by the RTL; empty under synthesis.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");

`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");

`else

`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons)

`define ASSERT_NEXT(label, clk, rst_n, ante, cons)

`endif

`endif

// File: rtl/core/crcfr_pkg.sv
// ---------------------------------------------------------------------------
// crcfr_pkg
// Types, codes and the CRC32C byte update for the frame receiver.
// ---------------------------------------------------------------------------
`default_nettype none

package crcfr_pkg;

  localparam logic [31:0] CRC_POLY      = 32'h82F63B78;
  localparam logic [31:0] CRC_INIT      = 32'hFFFFFFFF;
  localparam logic [24:0] PAYLOAD_LIMIT = 25'd16777216;

  localparam int TDATA_W = 176;
  localparam int CFG_IDX_W = 8;

  localparam logic [CFG_IDX_W-1:0] CFG_MAGIC_WORD  = 8'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_MAX_PAYLOAD = 8'd1;

  localparam logic KIND_PAYLOAD = 1'b0;
  localparam logic KIND_STATUS  = 1'b1;

  localparam logic [4:0] HDR_LAST = 5'd23;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_BAD_MAGIC = 2'd1,
    ST_TOO_LARGE = 2'd2,
    ST_CRC_ERR   = 2'd3
  } status_t;

  typedef enum logic [1:0] {
    PH_HEADER  = 2'd0,
    PH_PAYLOAD = 2'd1,
    PH_TRAILER = 2'd2,
    PH_HUNT    = 2'd3
  } phase_t;

  typedef struct packed {
    logic        kind;
    logic [7:0]  data_byte;
    status_t     status;
    logic [7:0]  version;
    logic [7:0]  msg_type;
    logic [15:0] msg_flags;
    logic [63:0] request_id;
    logic [31:0] length_seen;
    logic [31:0] crc_received;
  } result_t;

  function automatic logic [31:0] crc32c_byte(input logic [31:0] crc, input logic [7:0] b);
    logic [31:0] c;
    c = crc ^ {24'd0, b};
    for (int k = 0; k < 8; k++) begin
      c = (c >> 1) ^ (c[0] ? CRC_POLY : 32'd0);
    end
    return c;
  endfunction

endpackage

`default_nettype wire

// File: rtl/core/crcfr_parser.sv
// ---------------------------------------------------------------------------
// crcfr_parser
// Frame state machine: header fields, payload count, CRC and trailer check.
// ---------------------------------------------------------------------------
`default_nettype none

module crcfr_parser (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                step,
  input  wire logic [7:0]          rx_byte,
  input  wire logic [31:0]         magic_word,
  input  wire logic [24:0]         max_payload,
  output logic                     res_valid,
  output crcfr_pkg::result_t       res
);

  crcfr_pkg::phase_t phase_r, phase_nxt;
  logic [24:0] cnt_r, cnt_nxt;
  logic [31:0] magic_acc_r, magic_acc_nxt;
  logic [7:0]  version_r, version_nxt;
  logic [7:0]  type_r, type_nxt;
  logic [15:0] flags_r, flags_nxt;
  logic [63:0] reqid_r, reqid_nxt;
  logic [31:0] length_r, length_nxt;
  logic [31:0] crc_r, crc_nxt;
  logic [31:0] trailer_r, trailer_nxt;

  logic [4:0]  hidx;
  logic [4:0]  rid_off;
  logic [24:0] cnt_inc;
  logic [31:0] crc_upd;

  assign hidx    = cnt_r[4:0];
  assign rid_off = hidx - 5'd12;
  assign cnt_inc = cnt_r + 25'd1;
  assign crc_upd = crcfr_pkg::crc32c_byte(crc_r, rx_byte);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r     <= crcfr_pkg::PH_HEADER;
      cnt_r       <= '0;
      magic_acc_r <= '0;
      version_r   <= '0;
      type_r      <= '0;
      flags_r     <= '0;
      reqid_r     <= '0;
      length_r    <= '0;
      crc_r       <= crcfr_pkg::CRC_INIT;
      trailer_r   <= '0;
    end else if (step) begin
      phase_r     <= phase_nxt;
      cnt_r       <= cnt_nxt;
      magic_acc_r <= magic_acc_nxt;
      version_r   <= version_nxt;
      type_r      <= type_nxt;
      flags_r     <= flags_nxt;
      reqid_r     <= reqid_nxt;
      length_r    <= length_nxt;
      crc_r       <= crc_nxt;
      trailer_r   <= trailer_nxt;
    end
  end

  always_comb begin
    phase_nxt     = phase_r;
    cnt_nxt       = cnt_r;
    magic_acc_nxt = magic_acc_r;
    version_nxt   = version_r;
    type_nxt      = type_r;
    flags_nxt     = flags_r;
    reqid_nxt     = reqid_r;
    length_nxt    = length_r;
    crc_nxt       = crc_r;
    trailer_nxt   = trailer_r;
    res_valid     = 1'b0;
    res           = '0;

    case (phase_r)
      crcfr_pkg::PH_HEADER: begin
        cnt_nxt = cnt_inc;
        if (hidx < 5'd4) begin
          magic_acc_nxt[8*hidx[1:0] +: 8] = rx_byte;
          if (hidx == 5'd3) begin
            if (magic_acc_nxt != magic_word) begin
              res_valid    = 1'b1;
              res.kind     = crcfr_pkg::KIND_STATUS;
              res.status   = crcfr_pkg::ST_BAD_MAGIC;
              phase_nxt    = crcfr_pkg::PH_HUNT;
              cnt_nxt      = 25'd4;
            end else begin
              crc_nxt = crcfr_pkg::CRC_INIT;
            end
          end
        end else begin
          crc_nxt = crc_upd;
          case (hidx)
            5'd4:    version_nxt = rx_byte;
            5'd5:    type_nxt = rx_byte;
            5'd6:    flags_nxt[7:0] = rx_byte;
            5'd7:    flags_nxt[15:8] = rx_byte;
            default: begin
              if (hidx >= 5'd12 && hidx < 5'd20) begin
                reqid_nxt[8*rid_off[2:0] +: 8] = rx_byte;
              end else if (hidx >= 5'd20) begin
                length_nxt[8*hidx[1:0] +: 8] = rx_byte;
              end
            end
          endcase
          if (hidx == crcfr_pkg::HDR_LAST) begin
            trailer_nxt = '0;
            if (length_nxt > {7'd0, max_payload}) begin
              res_valid        = 1'b1;
              res.kind         = crcfr_pkg::KIND_STATUS;
              res.status       = crcfr_pkg::ST_TOO_LARGE;
              res.version      = version_r;
              res.msg_type     = type_r;
              res.msg_flags    = flags_r;
              res.request_id   = reqid_r;
              res.length_seen  = length_nxt;
              phase_nxt        = crcfr_pkg::PH_HUNT;
              cnt_nxt          = '0;
              magic_acc_nxt    = '0;
            end else begin
              cnt_nxt   = '0;
              phase_nxt = (length_nxt == 32'd0) ? crcfr_pkg::PH_TRAILER
                                                : crcfr_pkg::PH_PAYLOAD;
            end
          end
        end
      end

      crcfr_pkg::PH_PAYLOAD: begin
        crc_nxt       = crc_upd;
        cnt_nxt       = cnt_inc;
        if ({7'd0, cnt_inc} >= length_r) begin
          cnt_nxt   = '0;
          phase_nxt = crcfr_pkg::PH_TRAILER;
        end
        res_valid     = 1'b1;
        res.kind      = crcfr_pkg::KIND_PAYLOAD;
        res.data_byte = rx_byte;
      end

      crcfr_pkg::PH_TRAILER: begin
        trailer_nxt[8*cnt_r[1:0] +: 8] = rx_byte;
        cnt_nxt = {23'd0, cnt_r[1:0]} + 25'd1;
        if (cnt_r[1:0] == 2'd3) begin
          res_valid        = 1'b1;
          res.kind         = crcfr_pkg::KIND_STATUS;
          res.version      = version_r;
          res.msg_type     = type_r;
          res.msg_flags    = flags_r;
          res.request_id   = reqid_r;
          res.length_seen  = length_r;
          res.crc_received = trailer_nxt;
          cnt_nxt          = '0;
          if (~crc_r == trailer_nxt) begin
            res.status = crcfr_pkg::ST_OK;
            phase_nxt  = crcfr_pkg::PH_HEADER;
          end else begin
            res.status    = crcfr_pkg::ST_CRC_ERR;
            phase_nxt     = crcfr_pkg::PH_HUNT;
            magic_acc_nxt = '0;
          end
        end
      end

      crcfr_pkg::PH_HUNT: begin
        magic_acc_nxt = {rx_byte, magic_acc_r[31:8]};
        if (cnt_r < 25'd4) begin
          cnt_nxt = cnt_inc;
        end
        if (cnt_nxt >= 25'd4 && magic_acc_nxt == magic_word) begin
          phase_nxt = crcfr_pkg::PH_HEADER;
          cnt_nxt   = 25'd4;
          crc_nxt   = crcfr_pkg::CRC_INIT;
        end
      end

      default: begin
        phase_nxt = crcfr_pkg::PH_HEADER;
      end
    endcase
  end

endmodule

`default_nettype wire

// File: rtl/core/crc32c_frame_receiver.sv
// ---------------------------------------------------------------------------
// crc32c_frame_receiver
// CRC32C-checked frame receiver: header parse, payload pass-through, status.
// ---------------------------------------------------------------------------
// Takes one received byte per item and accepts a byte every clock while
// in_tready is high. Each byte is handled in the cycle it is accepted and
// its result, if any (a payload byte or a status item), sits in the output
// register from the next cycle on; in_tready drops only while that register
// holds an item that the sink has not taken. The single-byte CRC32C update
// from crc_r back into the state registers sets the one-byte-per-clock figure.
// Configuration writes are always taken and belong in idle periods.
`default_nettype none
`include "assert_macros.svh"

module crc32c_frame_receiver (
  input  wire logic                             clk,
  input  wire logic                             rst_n,
  // config channel
  input  wire logic                             cfg_valid,
  output logic                                  cfg_ready,
  input  wire logic [crcfr_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [31:0]                      cfg_data,
  // input stream
  input  wire logic                             in_tvalid,
  output logic                                  in_tready,
  input  wire logic [7:0]                       in_tdata,   // [7:0] rx_byte
  // result stream
  output logic                                  out_tvalid,
  input  wire logic                             out_tready,
  // [7:0] data_byte, [9:8] status, [17:10] version, [25:18] msg_type,
  // [41:26] msg_flags, [105:42] request_id, [137:106] length_seen,
  // [169:138] crc_received, [175:170] zero
  output logic [crcfr_pkg::TDATA_W-1:0]         out_tdata,
  output logic                                  out_tuser   // [0] kind
);

  logic [31:0] magic_word_r;
  logic [24:0] max_payload_r;

  logic                             out_tvalid_r, out_tvalid_nxt;
  logic [crcfr_pkg::TDATA_W-1:0]    out_tdata_r;
  logic                             out_tuser_r;

  logic                in_accept;
  logic                res_valid;
  crcfr_pkg::result_t  res;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      magic_word_r  <= '0;
      max_payload_r <= crcfr_pkg::PAYLOAD_LIMIT;
    end else if (cfg_valid) begin
      if (cfg_index == crcfr_pkg::CFG_MAGIC_WORD) begin
        magic_word_r <= cfg_data;
      end else if (cfg_index == crcfr_pkg::CFG_MAX_PAYLOAD) begin
        max_payload_r <= cfg_data[24:0];
      end
    end
  end

  assign in_tready = !out_tvalid_r || out_tready;
  assign in_accept = in_tvalid && in_tready;

  crcfr_parser u_parser (
    .clk         (clk),
    .rst_n       (rst_n),
    .step        (in_accept),
    .rx_byte     (in_tdata),
    .magic_word  (magic_word_r),
    .max_payload (max_payload_r),
    .res_valid   (res_valid),
    .res         (res)
  );

  always_comb begin
    out_tvalid_nxt = out_tvalid_r;
    if (in_accept) begin
      out_tvalid_nxt = res_valid;
    end else if (out_tready) begin
      out_tvalid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_tvalid_r <= 1'b0;
    end else begin
      out_tvalid_r <= out_tvalid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept && res_valid) begin
      out_tuser_r <= res.kind;
      out_tdata_r <= {6'd0, res.crc_received, res.length_seen, res.request_id,
                      res.msg_flags, res.msg_type, res.version, res.status,
                      res.data_byte};
    end
  end

  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = out_tdata_r;
  assign out_tuser  = out_tuser_r;

  `ASSERT_IMPLIES(a_payload_clean, clk, rst_n, out_tvalid_r && out_tuser_r == crcfr_pkg::KIND_PAYLOAD, out_tdata_r[crcfr_pkg::TDATA_W-1:8] == '0)
  `ASSERT_IMPLIES(a_status_clean, clk, rst_n, out_tvalid_r && out_tuser_r == crcfr_pkg::KIND_STATUS, out_tdata_r[7:0] == 8'd0)
  `ASSERT_NEXT(a_result_lands, clk, rst_n, in_accept && res_valid, out_tvalid_r)

endmodule

`default_nettype wire
